// File: rtl/lfpc8_pkg.sv
// Shared types, frame constants and the CRC-8 byte table for the frame parser.
// No dependencies; imported by lfpc8_parse and lidar_frame_parser_crc8.
package lfpc8_pkg;

    // Frame byte values
    localparam logic [7:0] HDR_BYTE  = 8'h55;
    localparam logic [7:0] KEY_BYTE  = 8'h07;
    localparam logic [7:0] STATUS_OK = 8'h00;
    localparam logic [7:0] END_BYTE  = 8'hAA;
    localparam logic [7:0] CRC_POLY  = 8'h31;

    localparam int DIST_W = 24;

    // Configuration register indexes
    localparam logic [0:0] REG_ALARM_LIMIT = 1'b0;
    localparam logic [0:0] REG_ALARM_PAUSE = 1'b1;

    // Position within the frame, one-hot; HUNT waits for the header
    typedef enum logic [7:0] {
        POS_HUNT   = 8'b0000_0001,
        POS_KEY    = 8'b0000_0010,
        POS_STATUS = 8'b0000_0100,
        POS_DIST0  = 8'b0000_1000,
        POS_DIST1  = 8'b0001_0000,
        POS_DIST2  = 8'b0010_0000,
        POS_CRC    = 8'b0100_0000,
        POS_END    = 8'b1000_0000
    } t_pos;

    typedef struct packed {
        logic [DIST_W-1:0] alarm_limit;
        logic              alarm_pause;
    } t_cfg;

    typedef struct packed {
        logic              frame_valid;
        logic [DIST_W-1:0] distance_value;
        logic              below_limit;
    } t_result;

    // CRC-8 table entry, poly 0x31, MSB first: constant table indexed by crc ^ byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] val);
        logic [7:0] c;
        c = val;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/lfpc8_parse.sv
// Frame tracker: header hunt, field checks, CRC-8 and distance assembly.
// Depends on lfpc8_pkg. Produces at most one result per accepted beat.
module lfpc8_parse
    import lfpc8_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    input  t_cfg       i_cfg,
    output logic       o_res_valid,
    output t_result    o_res
);

    t_pos              r_pos, n_pos;
    logic [7:0]        r_crc, n_crc;
    logic [DIST_W-1:0] r_dist, n_dist;
    logic              r_ok, n_ok;

    logic [7:0]        crc_upd;
    logic              end_ok;
    logic [DIST_W-1:0] dist_out;

    assign crc_upd  = crc8_byte(r_crc ^ i_rx_byte);
    assign end_ok   = r_ok && (i_rx_byte == END_BYTE);
    assign dist_out = end_ok ? r_dist : '0;

    // Next-state logic for one beat
    always_comb begin
        n_pos       = r_pos;
        n_crc       = r_crc;
        n_dist      = r_dist;
        n_ok        = r_ok;
        o_res_valid = 1'b0;
        case (r_pos)
            POS_HUNT: begin
                if (i_rx_byte == HDR_BYTE) begin
                    n_pos  = POS_KEY;
                    n_crc  = '0;
                    n_dist = '0;
                    n_ok   = 1'b1;
                end
            end
            POS_KEY: begin
                if (i_rx_byte != KEY_BYTE) n_ok = 1'b0;
                n_crc = crc_upd;
                n_pos = POS_STATUS;
            end
            POS_STATUS: begin
                if (i_rx_byte != STATUS_OK) n_ok = 1'b0;
                n_crc = crc_upd;
                n_pos = POS_DIST0;
            end
            POS_DIST0: begin
                n_dist = {r_dist[DIST_W-9:0], i_rx_byte};
                n_crc  = crc_upd;
                n_pos  = POS_DIST1;
            end
            POS_DIST1: begin
                n_dist = {r_dist[DIST_W-9:0], i_rx_byte};
                n_crc  = crc_upd;
                n_pos  = POS_DIST2;
            end
            POS_DIST2: begin
                n_dist = {r_dist[DIST_W-9:0], i_rx_byte};
                n_crc  = crc_upd;
                n_pos  = POS_CRC;
            end
            POS_CRC: begin
                if (i_rx_byte != r_crc) n_ok = 1'b0;
                n_pos = POS_END;
            end
            POS_END: begin
                o_res_valid = 1'b1;
                n_pos       = POS_HUNT;
                n_crc       = '0;
                n_dist      = '0;
                n_ok        = 1'b1;
            end
            default: begin
                n_pos = POS_HUNT;
            end
        endcase
    end

    // Result fields, meaningful when o_res_valid
    always_comb begin
        o_res.frame_valid    = end_ok;
        o_res.distance_value = dist_out;
        o_res.below_limit    = end_ok && !i_cfg.alarm_pause && (dist_out < i_cfg.alarm_limit);
    end

    // State update on accepted beats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= POS_HUNT;
            r_crc  <= '0;
            r_dist <= '0;
            r_ok   <= 1'b1;
        end else if (i_accept) begin
            r_pos  <= n_pos;
            r_crc  <= n_crc;
            r_dist <= n_dist;
            r_ok   <= n_ok;
        end
    end

endmodule

// File: rtl/lidar_frame_parser_crc8.sv
// Rangefinder frame parser: one beat per cycle while o_stall is low.
// The result of the end byte is registered into the output register, or the skid stage if that is held.
// Throughput: one byte per cycle; an output register plus a skid stage hold results,
// so input stalls only while both are full. Synchronous active-low reset: parser back
// to hunting, alarm_limit and alarm_pause cleared, output stages empty.
// Depends on lfpc8_pkg and lfpc8_parse.
module lidar_frame_parser_crc8
    import lfpc8_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_rx_byte,
    // result channel
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_frame_valid,
    output logic [DIST_W-1:0] o_distance_value,
    output logic              o_below_limit,
    // configuration
    input  logic              i_cfg_we,
    input  logic [0:0]        i_cfg_index,
    input  logic [DIST_W-1:0] i_cfg_data
);

    t_cfg    r_cfg;
    logic    in_acc;
    logic    res_valid;
    t_result res;

    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;
    logic    take;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ALARM_LIMIT: r_cfg.alarm_limit <= i_cfg_data;
                REG_ALARM_PAUSE: r_cfg.alarm_pause <= i_cfg_data[0];
                default:         r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_stall = r_skid_valid;
    assign in_acc  = i_valid && !o_stall;
    assign take    = r_out_valid && !i_stall;

    lfpc8_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_acc),
        .i_rx_byte   (i_rx_byte),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Output register and skid stage: valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) r_skid_valid <= 1'b0;
        end else if (in_acc && res_valid) begin
            if (r_out_valid && !take) r_skid_valid <= 1'b1;
            r_out_valid <= 1'b1;
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register and skid stage: payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) r_out <= r_skid;
        end else if (in_acc && res_valid) begin
            if (r_out_valid && !take) begin
                r_skid <= res;
            end else begin
                r_out <= res;
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_frame_valid    = r_out.frame_valid;
    assign o_distance_value = r_out.distance_value;
    assign o_below_limit    = r_out.below_limit;

`ifndef SYNTHESIS
    // skid stage only fills behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a beat while output register is empty");

    // a drained skid stage empties on the next cycle
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_stall) |=> !r_skid_valid)
        else $error("skid stage did not drain");

    // alarm only on a checked frame; failed frames carry zero distance
    a_alarm_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_frame_valid) |-> (!o_below_limit && (o_distance_value == '0)))
        else $error("failed frame carries alarm or distance");
`endif

endmodule

// File: verif/lidar_frame_parser_crc8_tb.sv
// Self-checking testbench for lidar_frame_parser_crc8: serial frames in, range results out.
// Needs lfpc8_pkg and the parser RTL; a scoreboard class predicts and checks every result.
`timescale 1ns / 1ps

module lidar_frame_parser_crc8_tb
    import lfpc8_pkg::*;
;

    localparam int HOLDOFF_CYCLES = 80;
    localparam int SETTLE_CYCLES  = 4;
    localparam int PHASE_BYTES    = 310;

    // How a generated frame is spoiled
    typedef enum int {
        FAULT_NONE,
        FAULT_KEY,
        FAULT_STATUS,
        FAULT_DATA,
        FAULT_CRC,
        FAULT_END
    } t_fault;

    // Frame tracker and result checker
    class frame_scoreboard;
        logic [DIST_W-1:0] alarm_threshold;
        logic              alarm_muted;
        t_pos              pos;
        logic [7:0]        crc;
        logic [DIST_W-1:0] dist_acc;
        logic              checks_ok;
        t_result           expected_frames[$];
        int                errors;
        int                frames_checked;
        int                valid_frames;
        int                alarms;

        function new();
            alarm_threshold = '0;
            alarm_muted     = 1'b0;
            pos             = POS_HUNT;
            crc             = '0;
            dist_acc        = '0;
            checks_ok       = 1'b1;
            errors          = 0;
            frames_checked  = 0;
            valid_frames    = 0;
            alarms          = 0;
        endfunction

        // CRC-8, poly 0x31, bit-serial LFSR form, MSB of the byte first
        static function logic [7:0] crc_step(logic [7:0] c, logic [7:0] b);
            logic fb;
            for (int i = 7; i >= 0; i--) begin
                fb = c[7] ^ b[i];
                c  = {c[6:0], 1'b0};
                if (fb) begin
                    c = c ^ CRC_POLY;
                end
            end
            return c;
        endfunction

        function void write_cfg(logic [0:0] idx, logic [DIST_W-1:0] data);
            if (idx == REG_ALARM_LIMIT) begin
                alarm_threshold = data;
            end else if (idx == REG_ALARM_PAUSE) begin
                alarm_muted = data[0];
            end
        endfunction

        // Advance the frame tracker by one accepted byte
        function void take_rx_byte(logic [7:0] b);
            t_result res;
            case (pos)
                POS_HUNT: begin
                    if (b == HDR_BYTE) begin
                        pos       = POS_KEY;
                        crc       = '0;
                        dist_acc  = '0;
                        checks_ok = 1'b1;
                    end
                end
                POS_KEY: begin
                    if (b != KEY_BYTE) checks_ok = 1'b0;
                    crc = crc_step(crc, b);
                    pos = POS_STATUS;
                end
                POS_STATUS: begin
                    if (b != STATUS_OK) checks_ok = 1'b0;
                    crc = crc_step(crc, b);
                    pos = POS_DIST0;
                end
                POS_DIST0, POS_DIST1, POS_DIST2: begin
                    dist_acc = {dist_acc[DIST_W-9:0], b};
                    crc      = crc_step(crc, b);
                    if (pos == POS_DIST0) pos = POS_DIST1;
                    else if (pos == POS_DIST1) pos = POS_DIST2;
                    else pos = POS_CRC;
                end
                POS_CRC: begin
                    if (b != crc) checks_ok = 1'b0;
                    pos = POS_END;
                end
                POS_END: begin
                    if (b != END_BYTE) checks_ok = 1'b0;
                    res.frame_valid    = checks_ok;
                    res.distance_value = checks_ok ? dist_acc : '0;
                    res.below_limit    = checks_ok && !alarm_muted &&
                                         (dist_acc < alarm_threshold);
                    expected_frames.push_back(res);
                    pos       = POS_HUNT;
                    crc       = '0;
                    dist_acc  = '0;
                    checks_ok = 1'b1;
                end
                default: pos = POS_HUNT;
            endcase
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_frames.size() == 0) begin
                $error("unexpected result: frame_valid=%0b distance_value=%0h below_limit=%0b",
                       got.frame_valid, got.distance_value, got.below_limit);
                errors++;
                return;
            end
            want = expected_frames.pop_front();
            frames_checked++;
            if (want.frame_valid) valid_frames++;
            if (want.below_limit) alarms++;
            if (got.frame_valid !== want.frame_valid) begin
                $error("frame_valid: expected %0b, got %0b", want.frame_valid, got.frame_valid);
                errors++;
            end
            if (got.distance_value !== want.distance_value) begin
                $error("distance_value: expected %06h, got %06h",
                       want.distance_value, got.distance_value);
                errors++;
            end
            if (got.below_limit !== want.below_limit) begin
                $error("below_limit: expected %0b, got %0b", want.below_limit, got.below_limit);
                errors++;
            end
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [7:0]        i_rx_byte;
    logic              o_valid;
    logic              i_stall;
    logic              o_frame_valid;
    logic [DIST_W-1:0] o_distance_value;
    logic              o_below_limit;
    logic              i_cfg_we;
    logic [0:0]        i_cfg_index;
    logic [DIST_W-1:0] i_cfg_data;

    frame_scoreboard   sb;
    logic [DIST_W-1:0] cur_limit;
    logic              quiet;
    logic              holdoff_req;
    int unsigned       bytes_sent;

    lidar_frame_parser_crc8 uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_rx_byte        (i_rx_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_frame_valid    (o_frame_valid),
        .o_distance_value (o_distance_value),
        .o_below_limit    (o_below_limit),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // One byte beat; random idle cycles ahead of it unless in the quiet stretch
    task automatic send_byte(input logic [7:0] b);
        @(negedge i_clk);
        while (!quiet && $urandom_range(99) < 12) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.take_rx_byte(b);
        bytes_sent++;
    endtask

    // Build a frame, optionally spoil one field, send the first 'keep' bytes
    task automatic send_frame(input logic [DIST_W-1:0] d, input t_fault fault, input int keep);
        logic [7:0] fb [8];
        logic [7:0] crc;
        fb[0] = HDR_BYTE;
        fb[1] = KEY_BYTE;
        fb[2] = STATUS_OK;
        fb[3] = d[23:16];
        fb[4] = d[15:8];
        fb[5] = d[7:0];
        if (fault == FAULT_KEY) fb[1] = fb[1] ^ 8'($urandom_range(1, 255));
        if (fault == FAULT_STATUS) fb[2] = fb[2] ^ 8'($urandom_range(1, 255));
        crc = '0;
        for (int k = 1; k <= 5; k++) crc = frame_scoreboard::crc_step(crc, fb[k]);
        fb[6] = crc;
        fb[7] = END_BYTE;
        // data hit after the CRC was taken, so only the CRC check catches it
        if (fault == FAULT_DATA) begin
            fb[3 + $urandom_range(2)] ^= 8'($urandom_range(1, 255));
        end
        if (fault == FAULT_CRC) fb[6] = fb[6] ^ 8'($urandom_range(1, 255));
        if (fault == FAULT_END) fb[7] = fb[7] ^ 8'($urandom_range(1, 255));
        for (int k = 0; k < keep; k++) send_byte(fb[k]);
    endtask

    // Distances cluster around the threshold and the range ends; some carry header and end bytes
    function automatic logic [DIST_W-1:0] pick_distance();
        int unsigned r;
        logic [DIST_W-1:0] d;
        r = $urandom_range(99);
        if (r < 25) begin
            d = cur_limit + DIST_W'($urandom_range(2)) - DIST_W'(1);
        end else if (r < 35) begin
            d = ($urandom_range(1) != 0) ? {DIST_W{1'b1}} : '0;
        end else if (r < 45) begin
            d = {HDR_BYTE, END_BYTE, 8'($urandom)};
        end else begin
            d = DIST_W'($urandom);
        end
        return d;
    endfunction

    // Mostly good frames, with spoiled and cut-short frames and line noise mixed in
    task automatic random_traffic(input int unsigned nbytes);
        int unsigned stop_at;
        int unsigned r;
        stop_at = bytes_sent + nbytes;
        while (bytes_sent < stop_at) begin
            r = $urandom_range(99);
            if (r < 70) begin
                send_frame(pick_distance(), FAULT_NONE, 8);
            end else if (r < 85) begin
                send_frame(pick_distance(),
                           t_fault'($urandom_range(int'(FAULT_KEY), int'(FAULT_END))), 8);
            end else if (r < 93) begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            end else begin
                send_frame(pick_distance(), FAULT_NONE, $urandom_range(1, 7));
            end
        end
    endtask

    // Drop valid and let every pending result come out
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [DIST_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.write_cfg(idx, data);
    endtask

    // Registers change only with the block drained; upper pause bits are junk
    task automatic apply_config(input logic [DIST_W-1:0] limit, input logic pause);
        wait_drained();
        write_reg(REG_ALARM_LIMIT, limit);
        write_reg(REG_ALARM_PAUSE, {23'($urandom), pause});
        cur_limit = limit;
    endtask

    // Receiver: random stalls, one long hold-off on request, none when quiet
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holdoff_req) begin
                holdoff_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLDOFF_CYCLES) @(negedge i_clk);
                i_stall <= 1'b0;
            end else if (quiet) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(99) < 12);
            end
        end
    end

    // Result beats
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result({o_frame_valid, o_distance_value, o_below_limit});
        end
    end

    // Stimulus
    initial begin
        sb          = new();
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_rx_byte   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        cur_limit   = '0;
        quiet       = 1'b0;
        holdoff_req = 1'b0;
        bytes_sent  = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: byte extremes as noise, zero distance, header and end
        // values inside the data, a bad key
        apply_config('0, 1'b0);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame('0, FAULT_NONE, 8);
        send_frame({HDR_BYTE, END_BYTE, HDR_BYTE}, FAULT_NONE, 8);
        send_frame({DIST_W{1'b1}}, FAULT_KEY, 8);

        apply_config({DIST_W{1'b1}}, 1'b0);
        random_traffic(PHASE_BYTES);

        apply_config({DIST_W{1'b1}}, 1'b1);
        random_traffic(PHASE_BYTES);

        // receiver holds off while frames keep coming, so the input backs up
        apply_config(DIST_W'($urandom), 1'b0);
        holdoff_req = 1'b1;
        repeat (6) send_frame(pick_distance(), FAULT_NONE, 8);
        random_traffic(PHASE_BYTES - 48);

        // back to back, no idling on either side
        apply_config(DIST_W'(1), 1'b0);
        quiet = 1'b1;
        random_traffic(PHASE_BYTES);
        quiet = 1'b0;

        // sender pauses mid-phase until all results are out
        apply_config(DIST_W'($urandom), 1'b0);
        random_traffic(PHASE_BYTES / 2);
        wait_drained();
        random_traffic(PHASE_BYTES / 2);

        wait_drained();
        $display("sent %0d bytes over six register settings; checked %0d frames",
                 bytes_sent, sb.frames_checked);
        $display("%0d frames passed all checks, %0d raised the alarm",
                 sb.valid_frames, sb.alarms);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("lidar_frame_parser_crc8_tb OK");
        end else begin
            $display("lidar_frame_parser_crc8_tb NOT OK");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("lidar_frame_parser_crc8_tb NOT OK");
        $finish;
    end

endmodule
